[src/xcd_pkg.sv]
// ----------------------------------------------------------------------------
// xcd_pkg
// Shared types and constants of the command deframer.
// ----------------------------------------------------------------------------
package xcd_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int PAY_AW        = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    // request kinds (s_tuser)
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // result kinds (m_tuser)
    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_STATUS  = 2'd1;
    localparam logic [1:0] CFG_FAIL    = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [7:0]  START_RESET   = 8'd170;
    localparam logic [7:0]  STATUS_RESET  = 8'd1;
    localparam logic [7:0]  FAIL_RESET    = 8'd7;
    localparam logic [15:0] TIMEOUT_RESET = 16'd50;

    // error reply layout
    localparam logic [2:0] REPLY_LAST   = 3'd4;
    localparam logic [7:0] REPLY_LENGTH = 8'd1;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_CMD   = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

    // one pending result as handed from the parser to the output stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] cmd;
        logic [7:0] cnt;
        logic       rd_zero;   // read beyond the store: data reads as zero
    } res_desc_t;

endpackage

[src/xcd_out_seq.sv]
// ----------------------------------------------------------------------------
// xcd_out_seq
// Result holding stage and output register; expands an error into five words.
// ----------------------------------------------------------------------------
module xcd_out_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             desc_load,
    input  xcd_pkg::res_desc_t desc_in,
    input  logic [7:0]       mem_rdata,
    input  logic [7:0]       start_byte,
    input  logic [7:0]       status_byte,
    input  logic [7:0]       fail_code,
    output logic             can_take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,   // cmd_code, param_count, out_byte
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast    // last_of_run
);
    import xcd_pkg::*;

    logic       d_valid_reg, d_valid_next;
    res_desc_t  d_reg;
    logic [2:0] beat_reg, beat_next;
    logic       m_valid_reg, m_valid_next;
    logic [23:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    logic       out_free, advance, last_beat, d_done;
    logic [7:0] reply_byte, beat_byte;

    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = d_valid_reg && out_free;
    assign last_beat = (d_reg.kind != KIND_ERROR) || (beat_reg == REPLY_LAST);
    assign d_done    = advance && last_beat;
    assign can_take  = !d_valid_reg || d_done;

    always_comb begin
        case (beat_reg)
            3'd0:    reply_byte = start_byte;
            3'd1:    reply_byte = status_byte;
            3'd2:    reply_byte = REPLY_LENGTH;
            3'd3:    reply_byte = fail_code;
            default: reply_byte = start_byte ^ status_byte ^ REPLY_LENGTH ^ fail_code;
        endcase
    end

    always_comb begin
        case (d_reg.kind)
            KIND_ERROR: beat_byte = reply_byte;
            KIND_DATA:  beat_byte = d_reg.rd_zero ? 8'd0 : mem_rdata;
            default:    beat_byte = 8'd0;
        endcase
    end

    always_comb begin
        d_valid_next = d_valid_reg;
        beat_next    = beat_reg;
        if (d_done) begin
            d_valid_next = 1'b0;
            beat_next    = 3'd0;
        end else if (advance) begin
            beat_next = beat_reg + 3'd1;
        end
        if (desc_load) begin
            d_valid_next = 1'b1;
        end
        m_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            beat_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= d_valid_next;
            beat_reg    <= beat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (desc_load) begin
            d_reg <= desc_in;
        end
        if (advance) begin
            m_data_reg <= {beat_byte, d_reg.cnt, d_reg.cmd};
            m_user_reg <= d_reg.kind;
            m_last_reg <= last_beat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

[src/xor_checked_command_deframer.sv]
// ----------------------------------------------------------------------------
// xor_checked_command_deframer
// Start byte / command / length / payload / XOR checksum frame parser.
// ----------------------------------------------------------------------------
// Input words (s_*): tuser selects a received byte, a 1 ms tick or a payload
// read. Bytes run through the frame parser; payload bytes land in a
// synchronous store with a write and a read port that reads are served from.
// Output words (m_*): tuser gives the kind: frame accepted (command, length),
// error reply byte (five words, tlast on the fifth) or payload read data.
// Config channel (cfg_*): index 0 start byte, 1 error status, 2 checksum fail
// code, 3 gap timeout in ms; always ready, write only while idle.
// Result path: a result word goes into the holding stage on accept, then into
// the output register once that is free, and from there it is on m_*.
// Throughput: one input word per cycle while the output drains; an error
// reply holds the input until its fifth word goes into the output register,
// and the next word goes in with the fifth reply word. The store read is
// registered and is the only memory port in the read path.
// Reset: parser to idle, config to defaults; the payload store is not
// cleared, so no startup pass. A stalled receiver stops m_*; one result
// waits in the holding stage, after which s_tready drops.
// ----------------------------------------------------------------------------
module xor_checked_command_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // rx_byte, read_index
    input  logic [1:0]  s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // cmd_code, param_count, out_byte
    output logic [1:0]  m_tuser,    // result_kind
    output logic        m_tlast,    // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import xcd_pkg::*;

    logic [7:0]  start_reg, status_reg, fail_reg;
    logic [15:0] timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        seen_reg, seen_next;

    logic [7:0]  mem [PAYLOAD_DEPTH];
    logic [7:0]  rdata_reg;
    logic        mem_we;

    logic        accept, can_take, desc_load;
    res_desc_t   desc;
    logic [7:0]  rx_byte, read_index;
    logic        timed_out;
    phase_t      phase_eff;
    logic [7:0]  xor_eff;
    logic [8:0]  pos_inc;

    assign rx_byte    = s_tdata[7:0];
    assign read_index = s_tdata[15:8];
    assign s_tready   = can_take;
    assign accept     = s_tvalid && can_take;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= START_RESET;
            status_reg  <= STATUS_RESET;
            fail_reg    <= FAIL_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START:   start_reg   <= cfg_data[7:0];
                CFG_STATUS:  status_reg  <= cfg_data[7:0];
                CFG_FAIL:    fail_reg    <= cfg_data[7:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // a long gap restarts the parser before the new byte is looked at
    assign timed_out = seen_reg && (elapsed_reg > timeout_reg);
    assign phase_eff = timed_out ? PH_IDLE : phase_reg;
    assign xor_eff   = timed_out ? 8'd0 : xor_reg;
    assign pos_inc   = {1'b0, pos_reg} + 9'd1;

    always_comb begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        xor_next     = xor_reg;
        elapsed_next = elapsed_reg;
        seen_next    = seen_reg;
        mem_we       = 1'b0;
        desc_load    = 1'b0;
        desc.kind    = KIND_DATA;
        desc.cmd     = 8'd0;
        desc.cnt     = 8'd0;
        desc.rd_zero = 32'(read_index) >= PAYLOAD_DEPTH;

        if (accept) begin
            case (s_tuser)
                REQ_BYTE: begin
                    elapsed_next = 16'd0;
                    seen_next    = 1'b1;
                    if (timed_out) begin
                        cmd_next = 8'd0;
                        len_next = 8'd0;
                        pos_next = 8'd0;
                    end
                    xor_next   = xor_eff;
                    phase_next = phase_eff;
                    case (phase_eff)
                        PH_IDLE: begin
                            if (rx_byte == start_reg) begin
                                phase_next = PH_CMD;
                                xor_next   = start_reg;
                            end
                        end
                        PH_CMD: begin
                            cmd_next   = rx_byte;
                            xor_next   = xor_eff ^ rx_byte;
                            phase_next = PH_LEN;
                        end
                        PH_LEN: begin
                            len_next   = rx_byte;
                            xor_next   = xor_eff ^ rx_byte;
                            pos_next   = 8'd0;
                            phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                        end
                        PH_DATA: begin
                            if (32'(pos_reg) >= PAYLOAD_DEPTH) begin
                                phase_next = PH_IDLE;
                                cmd_next   = 8'd0;
                                len_next   = 8'd0;
                                pos_next   = 8'd0;
                                xor_next   = 8'd0;
                            end else begin
                                mem_we   = 1'b1;
                                xor_next = xor_eff ^ rx_byte;
                                pos_next = pos_inc[7:0];
                                // covers the wrap past 255 as well
                                if (pos_inc >= {1'b0, len_reg}) begin
                                    phase_next = PH_CHECK;
                                end
                            end
                        end
                        PH_CHECK: begin
                            desc_load = 1'b1;
                            if (rx_byte == xor_eff) begin
                                desc.kind = KIND_ACCEPT;
                                desc.cmd  = cmd_reg;
                                desc.cnt  = len_reg;
                            end else begin
                                desc.kind = KIND_ERROR;
                            end
                            phase_next = PH_IDLE;
                            cmd_next   = 8'd0;
                            len_next   = 8'd0;
                            pos_next   = 8'd0;
                            xor_next   = 8'd0;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            cmd_next   = 8'd0;
                            len_next   = 8'd0;
                            pos_next   = 8'd0;
                            xor_next   = 8'd0;
                        end
                    endcase
                end
                REQ_TICK: begin
                    if (elapsed_reg != 16'hFFFF) begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                end
                REQ_READ: begin
                    desc_load = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cmd_reg     <= 8'd0;
            len_reg     <= 8'd0;
            pos_reg     <= 8'd0;
            xor_reg     <= 8'd0;
            elapsed_reg <= 16'd0;
            seen_reg    <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            xor_reg     <= xor_next;
            elapsed_reg <= elapsed_next;
            seen_reg    <= seen_next;
        end
    end

    // payload store: written by data bytes, read by read requests
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[pos_reg[PAY_AW-1:0]] <= rx_byte;
        end
        if (accept && (s_tuser == REQ_READ)) begin
            rdata_reg <= mem[read_index[PAY_AW-1:0]];
        end
    end

    xcd_out_seq u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .desc_load   (desc_load),
        .desc_in     (desc),
        .mem_rdata   (rdata_reg),
        .start_byte  (start_reg),
        .status_byte (status_reg),
        .fail_code   (fail_reg),
        .can_take    (can_take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

[dv/xor_checked_command_deframer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_checked_command_deframer_checker
// Watches the input, result and register channels of the command deframer,
// keeps its own copy of the parser state, and checks each result word in
// order against the one predicted for it.
// ----------------------------------------------------------------------------
module xor_checked_command_deframer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          pending,
    output logic        parse_idle,
    output int          stored_count,   // payload entries 0..stored_count-1 written
    output int          n_checked,
    output int          n_accepted,
    output int          n_rejected
);
    import xcd_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] cmd;
        logic [7:0] cnt;
        logic [7:0] data;
        logic       last;
    } deframe_result_t;

    deframe_result_t reply_q[$];

    // register copies
    logic [7:0]  start_val;
    logic [7:0]  status_val;
    logic [7:0]  fail_val;
    logic [15:0] gap_limit;

    // parser copy
    phase_t      phase;
    logic [7:0]  cmd_hold;
    logic [7:0]  len_hold;
    logic [7:0]  pos;
    logic [7:0]  xor_acc;
    logic [7:0]  store [PAYLOAD_DEPTH];
    logic [15:0] elapsed;
    logic        seen;

    function automatic deframe_result_t mk_result(logic [1:0] kind, logic [7:0] cmd,
                                                  logic [7:0] cnt, logic [7:0] data,
                                                  logic last);
        deframe_result_t r;
        r.kind = kind;
        r.cmd  = cmd;
        r.cnt  = cnt;
        r.data = data;
        r.last = last;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    task automatic clear_frame();
        phase    = PH_IDLE;
        cmd_hold = '0;
        len_hold = '0;
        pos      = '0;
        xor_acc  = '0;
    endtask

    task automatic take_word(input logic [1:0] req, input logic [7:0] b,
                             input logic [7:0] idx);
        logic [7:0] reply [5];
        case (req)
            REQ_BYTE: begin
                if (seen && elapsed > gap_limit)
                    clear_frame();
                elapsed = '0;
                seen    = 1'b1;
                case (phase)
                    PH_IDLE: begin
                        if (b == start_val) begin
                            phase   = PH_CMD;
                            xor_acc = start_val;
                        end
                    end
                    PH_CMD: begin
                        cmd_hold = b;
                        xor_acc ^= b;
                        phase    = PH_LEN;
                    end
                    PH_LEN: begin
                        len_hold = b;
                        xor_acc ^= b;
                        pos      = '0;
                        phase    = (b == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA: begin
                        if (int'(pos) >= PAYLOAD_DEPTH) begin
                            clear_frame();
                        end else begin
                            store[pos] = b;
                            if (int'(pos) + 1 > stored_count)
                                stored_count = int'(pos) + 1;
                            xor_acc ^= b;
                            pos = pos + 8'd1;
                            if (pos >= len_hold || pos == 8'd0)
                                phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        if (b == xor_acc) begin
                            reply_q.push_back(mk_result(KIND_ACCEPT, cmd_hold, len_hold,
                                                        8'd0, 1'b1));
                        end else begin
                            reply[0] = start_val;
                            reply[1] = status_val;
                            reply[2] = REPLY_LENGTH;
                            reply[3] = fail_val;
                            reply[4] = reply[0] ^ reply[1] ^ reply[2] ^ reply[3];
                            for (int i = 0; i < 5; i++)
                                reply_q.push_back(mk_result(KIND_ERROR, 8'd0, 8'd0, reply[i],
                                                            i == int'(REPLY_LAST)));
                        end
                        clear_frame();
                    end
                    default: clear_frame();
                endcase
            end
            REQ_TICK: begin
                if (elapsed != 16'hFFFF)
                    elapsed = elapsed + 16'd1;
            end
            REQ_READ: begin
                reply_q.push_back(mk_result(KIND_DATA, 8'd0, 8'd0,
                                            (int'(idx) < PAYLOAD_DEPTH) ? store[idx] : 8'd0,
                                            1'b1));
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input deframe_result_t got);
        deframe_result_t want;
        if (reply_q.size() == 0) begin
            report($sformatf("unexpected word: kind %0d cmd %02h cnt %02h data %02h last %0d",
                             got.kind, got.cmd, got.cnt, got.data, got.last));
            return;
        end
        want = reply_q.pop_front();
        check_field("result_kind", got.kind, want.kind);
        check_field("cmd_code", got.cmd, want.cmd);
        check_field("param_count", got.cnt, want.cnt);
        check_field("out_byte", got.data, want.data);
        check_field("last_of_run", got.last, want.last);
        n_checked++;
        if (want.kind == KIND_ACCEPT)
            n_accepted++;
        else if (want.kind == KIND_ERROR && want.last)
            n_rejected++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            start_val    = START_RESET;
            status_val   = STATUS_RESET;
            fail_val     = FAIL_RESET;
            gap_limit    = TIMEOUT_RESET;
            clear_frame();
            elapsed      = '0;
            seen         = 1'b0;
            stored_count = 0;
            mismatches   = 0;
            n_checked    = 0;
            n_accepted   = 0;
            n_rejected   = 0;
            reply_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_START:   start_val  = cfg_data[7:0];
                    CFG_STATUS:  status_val = cfg_data[7:0];
                    CFG_FAIL:    fail_val   = cfg_data[7:0];
                    CFG_TIMEOUT: gap_limit  = cfg_data;
                    default: ;
                endcase
            end
            // a result word always stems from an earlier input word, so check first
            if (m_tvalid && m_tready)
                check_result({m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tlast});
            if (s_tvalid && s_tready)
                take_word(s_tuser, s_tdata[7:0], s_tdata[15:8]);
        end
        pending    = reply_q.size();
        parse_idle = (phase == PH_IDLE);
    end

endmodule

[dv/xor_checked_command_deframer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_checked_command_deframer_tb
// Drives byte, tick and read words into the command deframer: a directed
// pass over the corner cases, then random frames, noise, broken frames and
// reads under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module xor_checked_command_deframer_tb;
    import xcd_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         PHASE_WORDS = 35;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b1;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int   mismatches, pending, stored_count, n_checked, n_accepted, n_rejected;
    logic parse_idle;

    bit          calm = 1'b0;
    logic [7:0]  cur_start   = START_RESET;
    int          cur_timeout = TIMEOUT_RESET;
    int          words_sent  = 0;
    int          settings    = 1;
    int          quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    xor_checked_command_deframer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    xor_checked_command_deframer_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches), .pending(pending), .parse_idle(parse_idle),
        .stored_count(stored_count), .n_checked(n_checked), .n_accepted(n_accepted),
        .n_rejected(n_rejected)
    );

    // receiver stalls
    always @(negedge aclk)
        m_tready <= (!aresetn || calm) ? 1'b1 : ($urandom_range(99) >= 35);

    // watchdog: cycles with no word moving on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("** xor_checked_command_deframer: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called and returns at a falling edge
    task automatic send_word(input logic [1:0] req, input logic [7:0] b,
                             input logic [7:0] idx);
        while (!calm && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {idx, b};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        if (req != REQ_UNUSED)
            words_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_word(REQ_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word(REQ_BYTE, b, 8'($urandom_range(255)));
    endtask

    // stop sending and let every expected word drain
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_registers(input logic [7:0] start_b, input logic [7:0] status_b,
                                 input logic [7:0] fail_b, input logic [15:0] timeout);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        quiesce();
        idx = '{CFG_START, CFG_STATUS, CFG_FAIL, CFG_TIMEOUT};
        val = '{{8'($urandom_range(255)), start_b}, {8'($urandom_range(255)), status_b},
                {8'($urandom_range(255)), fail_b}, timeout};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid   <= 1'b0;
        cur_start   = start_b;
        cur_timeout = timeout;
        settings++;
    endtask

    // push the parser back to idle with filler bytes
    task automatic settle_parser();
        while (!parse_idle)
            send_byte(8'($urandom_range(255)));
    endtask

    // cut >= 0 stops after that many payload bytes
    task automatic send_frame(input logic [7:0] cmd, input int len, input bit good,
                              input int tick_max, input int cut);
        logic [7:0] sum;
        logic [7:0] pay;
        settle_parser();
        sum = cur_start ^ cmd ^ 8'(len);
        send_byte(cur_start);
        for (int k = -1; k <= len; k++) begin
            if (k == cut && k >= 0)
                return;
            if (tick_max > 0 && $urandom_range(3) == 0)
                send_ticks($urandom_range(tick_max, 1));
            if (k == -1) begin
                send_byte(cmd);
                send_byte(8'(len));
            end else if (k < len) begin
                pay = 8'($urandom_range(255));
                sum ^= pay;
                send_byte(pay);
            end else begin
                send_byte(good ? sum : sum ^ 8'($urandom_range(255, 1)));
            end
        end
    endtask

    // start, command C3 and zero length, a tick gap, then the checksum; the
    // frame is accepted only if the gap did not restart the parser
    task automatic restart_probe(input int ticks);
        settle_parser();
        send_byte(cur_start);
        send_byte(8'hC3);
        send_byte(8'h00);
        send_ticks(ticks);
        send_byte(cur_start ^ 8'hC3);
    endtask

    task automatic random_unit();
        int roll;
        int len;
        int tick_max;
        roll     = $urandom_range(99);
        tick_max = (cur_timeout <= 8) ? cur_timeout : 5;
        len      = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(40, 7);
        if (roll < 60) begin
            send_frame(8'($urandom_range(255)), len, $urandom_range(99) < 70, tick_max, -1);
        end else if (roll < 72) begin
            if (stored_count > 0)
                send_word(REQ_READ, 8'($urandom_range(255)),
                          8'($urandom_range(stored_count - 1)));
        end else if (roll < 80) begin
            send_ticks($urandom_range(5, 1));
        end else if (roll < 88) begin
            send_byte(8'($urandom_range(255)));
        end else if (roll < 95) begin
            len = $urandom_range(8, 2);
            send_frame(8'($urandom_range(255)), len, 1'b1, tick_max, $urandom_range(len - 1));
            if (cur_timeout < 200)
                send_ticks(cur_timeout + 1);
        end else begin
            send_word(REQ_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        int target;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, registers at their reset values
        send_frame(8'h00, 0, 1'b1, 0, -1);
        send_frame(8'hFF, 3, 1'b1, 0, -1);
        for (int i = 0; i < 3; i++)
            send_word(REQ_READ, 8'($urandom_range(255)), 8'(i));
        send_frame(8'h5A, 2, 1'b0, 0, -1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_word(REQ_UNUSED, 8'hFF, 8'hFF);
        restart_probe(cur_timeout + 1);
        restart_probe(cur_timeout);

        // register extremes: zero timeout restarts on any tick between bytes
        set_registers(8'h00, 8'hFF, 8'h00, 16'd0);
        send_frame(8'h44, 1, 1'b0, 0, -1);
        send_frame(8'h45, 2, 1'b1, 0, -1);
        restart_probe(1);
        restart_probe(0);

        // near-maximum limit: short gaps never restart the parser
        set_registers(8'hFF, 8'h00, 8'hFF, 16'd65534);
        restart_probe(2);
        send_frame(8'hA5, 20, 1'b1, 3, -1);
        send_word(REQ_READ, 8'h00, 8'(stored_count - 1));
        send_word(REQ_READ, 8'hFF, 8'd0);

        // random phases
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 16'd3);
                1: set_registers(START_RESET, STATUS_RESET, FAIL_RESET, TIMEOUT_RESET);
                2: set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 16'd65535);
                default: set_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                                       8'($urandom_range(255)), 16'd0);
            endcase
            calm   = (p == 1);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                random_unit();
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Covered %0d input words under %0d register settings, %0d results checked.",
                 words_sent, settings, n_checked);
        $display("Frames: %0d accepted, %0d answered with an error reply.",
                 n_accepted, n_rejected);
        if (mismatches == 0) begin
            $display("** xor_checked_command_deframer: PASSED **");
        end else begin
            $display("** xor_checked_command_deframer: FAILED **");
        end
        $finish;
    end

endmodule
